### hw/rtl/sst_pkg.sv
// Package for the script source tokenizer: sizes, request and token codes,
// character constants and the keyword and operator lookup functions.
// No dependencies.
package sst_pkg;

	localparam int MAX_SOURCE = 4096;
	localparam int AW = $clog2(MAX_SOURCE);
	localparam int PW = $clog2(MAX_SOURCE + 1);
	localparam int TOK_W = 13;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_FETCH  = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [4:0] TT_KEYWORD  = 5'd0;
	localparam logic [4:0] TT_NAME     = 5'd1;
	localparam logic [4:0] TT_NUMBER   = 5'd2;
	localparam logic [4:0] TT_STRING   = 5'd3;
	localparam logic [4:0] TT_ARITH    = 5'd4;
	localparam logic [4:0] TT_ASSIGN   = 5'd5;
	localparam logic [4:0] TT_REL      = 5'd6;
	localparam logic [4:0] TT_LOGIC    = 5'd7;
	localparam logic [4:0] TT_BITWISE  = 5'd8;
	localparam logic [4:0] TT_BLK_BEG  = 5'd9;
	localparam logic [4:0] TT_BLK_END  = 5'd10;
	localparam logic [4:0] TT_LPAREN   = 5'd11;
	localparam logic [4:0] TT_RPAREN   = 5'd12;
	localparam logic [4:0] TT_LBRACK   = 5'd13;
	localparam logic [4:0] TT_RBRACK   = 5'd14;
	localparam logic [4:0] TT_TERM     = 5'd15;
	localparam logic [4:0] TT_DOT      = 5'd16;
	localparam logic [4:0] TT_COMMA    = 5'd17;
	localparam logic [4:0] TT_INC      = 5'd18;
	localparam logic [4:0] TT_DEC      = 5'd19;
	localparam logic [4:0] TT_COLON    = 5'd20;
	localparam logic [4:0] TT_COMMENT  = 5'd21;
	localparam logic [4:0] TT_UNKNOWN  = 5'd22;

	// keyword slots 0..7, then the two block words
	localparam int NUM_KW = 8;
	localparam int KW_DO = 8;
	localparam int KW_END = 9;
	localparam int NUM_WORDS = 10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_US    = "_";

	typedef struct packed {
		logic [4:0] ty;
		logic       two;
	} op_res_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_US;
	endfunction

	function automatic logic [2:0] kw_len(int k);
		logic [2:0] l;
		case (k)
			0: l = 3'd5;
			1: l = 3'd4;
			2: l = 3'd6;
			3: l = 3'd2;
			4: l = 3'd4;
			5: l = 3'd4;
			6: l = 3'd3;
			7: l = 3'd5;
			8: l = 3'd2;
			default: l = 3'd3;
		endcase
		return l;
	endfunction

	// character i of word k, text right-justified in 48 bits
	function automatic logic [7:0] kw_char(int k, logic [2:0] i);
		logic [47:0] s;
		logic [5:0]  sh;
		case (k)
			0: s = 48'("class");
			1: s = 48'("func");
			2: s = 48'("return");
			3: s = 48'("if");
			4: s = 48'("elif");
			5: s = 48'("else");
			6: s = 48'("for");
			7: s = 48'("while");
			8: s = 48'("do");
			default: s = 48'("end");
		endcase
		sh = 6'((kw_len(k) - 3'd1 - i) * 4'd8);
		return 8'(s >> sh);
	endfunction

	// first-match operator/special decode, c1 valid only when has1
	function automatic op_res_t op_class(logic [7:0] c, logic [7:0] c1, logic has1);
		op_res_t r;
		logic    eq;
		eq = has1 && c1 == "=";
		r.two = 1'b0;
		case (c)
			"{":  r.ty = TT_BLK_BEG;
			"}":  r.ty = TT_BLK_END;
			"(":  r.ty = TT_LPAREN;
			")":  r.ty = TT_RPAREN;
			"[":  r.ty = TT_LBRACK;
			"]":  r.ty = TT_RBRACK;
			";", CH_LF: r.ty = TT_TERM;
			".":  r.ty = TT_DOT;
			",":  r.ty = TT_COMMA;
			":":  r.ty = TT_COLON;
			"+": begin
				if (has1 && c1 == "+") begin
					r.ty = TT_INC; r.two = 1'b1;
				end else if (eq) begin
					r.ty = TT_ASSIGN; r.two = 1'b1;
				end else r.ty = TT_ARITH;
			end
			"-": begin
				if (has1 && c1 == "-") begin
					r.ty = TT_DEC; r.two = 1'b1;
				end else if (eq) begin
					r.ty = TT_ASSIGN; r.two = 1'b1;
				end else r.ty = TT_ARITH;
			end
			"=": begin
				r.ty = eq ? TT_REL : TT_ASSIGN; r.two = eq;
			end
			"!": begin
				r.ty = eq ? TT_REL : TT_LOGIC; r.two = eq;
			end
			">", "<": r.ty = TT_REL;
			"*", "/", "%": begin
				r.ty = eq ? TT_ASSIGN : TT_ARITH; r.two = eq;
			end
			"&", "|", "^", "~": r.ty = TT_BITWISE;
			default: r.ty = TT_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/sst_req_if.sv
// Request channel of the tokenizer: valid/ready plus kind and source byte.
// Depends on sst_pkg.
interface sst_req_if
	import sst_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] source_byte;

	modport source (output valid, kind, source_byte, input ready);
	modport sink (input valid, kind, source_byte, output ready);
endinterface

### hw/rtl/sst_tok_if.sv
// Token channel of the tokenizer: valid/ready plus the token fields.
// Depends on sst_pkg.
interface sst_tok_if
	import sst_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [4:0]       token_type;
	logic [TOK_W-1:0] token_start;
	logic [TOK_W-1:0] token_length;
	logic             no_more;
	logic             overflow;

	modport source (output valid, token_type, token_start, token_length, no_more, overflow,
		input ready);
	modport sink (input valid, token_type, token_start, token_length, no_more, overflow,
		output ready);
endinterface

### hw/rtl/sst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/script_source_tokenizer_core.sv
// Script source tokenizer: source buffer in a RAM and a byte-serial scanner.
// Depends on sst_pkg, sst_req_if, sst_tok_if and sst_ram.
//
// Usage. The req channel carries one transaction per request: kind 0 appends
// source_byte to the buffer (dropped and flagged once the buffer holds
// MAX_SOURCE bytes), kind 2 clears the buffer and scan position, kind 1
// fetches the next token, which comes back as one transaction on the tok
// channel. Kind 3 is taken and ignored.
// A fetch walks the buffer one byte per cycle through the RAM read port.
// It skips blanks, then examines the bytes of a word, number, string or
// comment and the byte (or end of buffer) that ends it. An operator or a
// one-byte unknown examines its own byte and the next, a fetch with nothing
// left returns a no_more token, and an unterminated quote scans to the end
// of the buffer.
// The token sits in an output register; while it waits, requests are still
// taken if the sink takes it in the same cycle, otherwise req.ready is low.
// Reset empties the buffer (count, scan position and overflow flag to zero);
// no RAM clearing pass is needed since only written bytes are ever read.
module script_source_tokenizer_core
	import sst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sst_req_if.sink   req,
	sst_tok_if.source tok
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SKIP = 6'b000010,
		ST_WORD = 6'b000100,
		ST_NUM  = 6'b001000,
		ST_STR  = 6'b010000,
		ST_CMT  = 6'b100000
	} state_t;
	// ST_CMT also resolves operators; op_q tells the two apart
	state_t state_q, state_d;

	logic [PW-1:0] count_q, scan_q, ptr_q, start_q, alpha_end_q;
	logic          drop_q, alpha_on_q, dot_q, op_q;
	logic [7:0]    c0_q;
	logic [NUM_WORDS-1:0] flag_q, flag_d;

	logic          ov_q, onomore_q, oovf_q;
	logic [4:0]    otype_q;
	logic [TOK_W-1:0] ostart_q, olen_q;

	logic [7:0]    rd_data;
	logic [AW-1:0] raddr;
	logic          wr_en;
	logic          acc, eof, fin, f_nomore;
	logic [PW-1:0] idx, alen, f_start, f_len, f_next;
	logic [4:0]    f_type;
	logic          kw_hit;
	op_res_t       opr;

	assign req.ready = (state_q == ST_IDLE) && (!ov_q || tok.ready);
	assign acc = req.valid && req.ready;
	assign wr_en = acc && req.kind == KIND_APPEND && count_q < PW'(MAX_SOURCE);
	assign raddr = (state_q == ST_IDLE) ? scan_q[AW-1:0] : AW'(ptr_q + PW'(1));

	sst_ram #(.WIDTH(8), .DEPTH(MAX_SOURCE)) u_src (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (req.source_byte),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign eof = ptr_q >= count_q;
	assign idx = ptr_q - start_q;
	assign alen = (alpha_on_q ? ptr_q : alpha_end_q) - start_q;
	assign opr = op_class(c0_q, rd_data, !eof);

	always_comb begin
		kw_hit = 1'b0;
		for (int k = 0; k < NUM_KW; k++)
			if (flag_q[k] && alen == PW'(kw_len(k))) kw_hit = 1'b1;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (state_q == ST_SKIP)
				flag_d[k] = rd_data == kw_char(k, 3'd0);
			else
				flag_d[k] = flag_q[k] &&
					(idx >= PW'(kw_len(k)) || rd_data == kw_char(k, idx[2:0]));
		end
	end

	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		f_nomore = 1'b0;
		f_type   = TT_UNKNOWN;
		f_start  = start_q;
		f_len    = PW'(1);
		f_next   = start_q + PW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.kind == KIND_FETCH) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (eof) begin
					fin = 1'b1; f_nomore = 1'b1; f_type = '0;
					f_start = '0; f_len = '0; f_next = count_q;
				end else if (rd_data == CH_SPACE || rd_data == CH_TAB || rd_data == CH_CR) begin
					state_d = ST_SKIP;
				end else if (is_alpha(rd_data) || rd_data == CH_US) begin
					state_d = ST_WORD;
				end else if (is_digit(rd_data)) begin
					state_d = ST_NUM;
				end else if (rd_data == CH_DQ || rd_data == CH_SQ) begin
					state_d = ST_STR;
				end else begin
					state_d = ST_CMT;
				end
			end
			ST_WORD: begin
				if (eof || !is_word(rd_data)) begin
					fin = 1'b1;
					if (kw_hit) begin
						f_type = TT_KEYWORD; f_len = alen;
					end else if (idx == PW'(2) && flag_q[KW_DO]) begin
						f_type = TT_BLK_BEG; f_len = idx;
					end else if (idx == PW'(3) && flag_q[KW_END]) begin
						f_type = TT_BLK_END; f_len = idx;
					end else begin
						f_type = TT_NAME; f_len = idx;
					end
					f_next = start_q + f_len;
				end
			end
			ST_NUM: begin
				if (eof || !(is_digit(rd_data) || rd_data == CH_DOT)) begin
					fin = 1'b1; f_type = TT_NUMBER;
					f_len = dot_q ? idx - PW'(1) : idx;
					f_next = start_q + f_len;
				end
			end
			ST_STR: begin
				if (eof) begin
					fin = 1'b1;
				end else if (rd_data == c0_q) begin
					fin = 1'b1; f_type = TT_STRING;
					f_start = start_q + PW'(1); f_len = idx - PW'(1);
					f_next = ptr_q + PW'(1);
				end
			end
			ST_CMT: begin
				if (op_q) begin
					fin = 1'b1; f_type = opr.ty;
					f_len = opr.two ? PW'(2) : PW'(1);
					f_next = start_q + f_len;
				end else if (eof || rd_data == CH_LF) begin
					fin = 1'b1; f_type = TT_COMMENT;
					f_start = start_q + PW'(1); f_len = idx - PW'(1);
					f_next = eof ? ptr_q : ptr_q + PW'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) state_d = ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			drop_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && req.kind == KIND_APPEND) begin
				if (wr_en) count_q <= count_q + PW'(1);
				else drop_q <= 1'b1;
			end
			if (acc && req.kind == KIND_CLEAR) begin
				count_q <= '0;
				scan_q  <= '0;
				drop_q  <= 1'b0;
			end
			if (fin) scan_q <= f_next;
			if (fin) ov_q <= 1'b1;
			else if (tok.ready) ov_q <= 1'b0;
		end
	end

	// scanner datapath and output register
	always_ff @(posedge clk) begin
		if (acc) ptr_q <= scan_q;
		else if (state_q != ST_IDLE) ptr_q <= ptr_q + PW'(1);
		flag_q <= flag_d;
		if (state_q == ST_SKIP) begin
			start_q     <= ptr_q;
			c0_q        <= rd_data;
			alpha_on_q  <= is_alpha(rd_data);
			alpha_end_q <= ptr_q;
			dot_q       <= 1'b0;
			op_q        <= rd_data != CH_HASH;
		end else begin
			if (alpha_on_q && !is_alpha(rd_data)) begin
				alpha_on_q  <= 1'b0;
				alpha_end_q <= ptr_q;
			end
			dot_q <= rd_data == CH_DOT;
		end
		if (fin) begin
			otype_q   <= f_type;
			ostart_q  <= TOK_W'(f_start);
			olen_q    <= TOK_W'(f_len);
			onomore_q <= f_nomore;
			oovf_q    <= drop_q;
		end
	end

	assign tok.valid        = ov_q;
	assign tok.token_type   = otype_q;
	assign tok.token_start  = ostart_q;
	assign tok.token_length = olen_q;
	assign tok.no_more      = onomore_q;
	assign tok.overflow     = oovf_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= count_q) else $error("scan position beyond buffer fill");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PW'(MAX_SOURCE)) else $error("buffer fill beyond capacity");
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> ptr_q <= count_q) else $error("scan pointer past end");
	a_fetch_starts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.kind == KIND_FETCH |=> state_q == ST_SKIP)
		else $error("fetch did not start scanning");
	a_no_more_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fin && f_nomore |=> tok.token_type == '0 && tok.token_start == '0 &&
		tok.token_length == '0) else $error("no_more token carries fields");
endmodule
